/* design/askc_pkg.sv */
// Shared types, constants and helper functions for the adaptive sampling k-mer counter.
`default_nettype none
package askc_pkg;

  localparam int HASH_W   = 64;
  localparam int LEVEL_W  = 7;
  localparam int COUNT_W  = 32;
  localparam int LIMIT_W  = 13;
  localparam int QFREQ_W  = 7;
  localparam int EST_W    = 64;
  localparam int TOP_LEVEL = 64;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_SAMPLE_LIMIT = 3'd0;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 13'd4096;

  // Opcodes carried on the input side-band
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_QUERY  = 1'b1;

  // One table entry as stored in the memory
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] level;
    logic [HASH_W-1:0]  hash;
    logic [COUNT_W-1:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Count of trailing zero bits; zero maps to the top level
  function automatic logic [LEVEL_W-1:0] trailing_level(input logic [HASH_W-1:0] h);
    logic [LEVEL_W-1:0] n;
    n = LEVEL_W'(TOP_LEVEL);
    for (int i = HASH_W - 1; i >= 0; i--) begin
      if (h[i]) n = LEVEL_W'(i);
    end
    return n;
  endfunction

  // Shift left by the level, saturating to all ones
  function automatic logic [EST_W-1:0] scale_sat(input logic [EST_W-1:0] v,
                                                 input logic [LEVEL_W-1:0] sh);
    logic [EST_W-1:0] s;
    logic [EST_W-1:0] r;
    s = v << sh;
    if (v == '0) r = '0;
    else if (sh >= LEVEL_W'(EST_W)) r = '1;
    else if ((s >> sh) != v) r = '1;
    else r = s;
    return r;
  endfunction

endpackage
`default_nettype wire

/* design/adaptive_sampling_kmer_counter_top.sv */
// Sequence: an insert walks the table until its hash is found, plus one more walk
// per dropped level; a query walks once, an insert below the threshold does not walk.
// Requests: one at a time; the walk over the single table memory sets the rate.
// Reset: synchronous active-low; afterward a clearing pass writes every row of the table
// memory before the first request is taken (config writes still work).
`default_nettype none
module adaptive_sampling_kmer_counter_top #(
  parameter int TABLE_CAPACITY = 4096,
  parameter int MAX_FREQUENCY  = 64
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // tuser: opcode[0]
  input  wire logic                               in_tuser,
  // tdata: hash_value[63:0], query_frequency[70:64], zero pad [71]
  input  wire logic [askc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // tdata: threshold_level[6:0], distinct_estimate[70:7], kmer_total[134:71],
  //        frequency_estimate[198:135], zero pad [199]
  output      logic [askc_pkg::OUT_DATA_W-1:0]    out_tdata,
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  input  wire logic                               cfg_psel,
  input  wire logic                               cfg_penable,
  input  wire logic                               cfg_pwrite,
  input  wire logic [askc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [askc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output      logic [askc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output      logic                               cfg_pready
);
  import askc_pkg::*;

  localparam int AW = $clog2(TABLE_CAPACITY);
  localparam int CW = AW + 1;
  localparam logic [CW-1:0] CAP = CW'(TABLE_CAPACITY);
  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_CAPACITY - 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LEVEL, S_LVCHK, S_SCAN, S_INSERT, S_EVCHK, S_EVICT, S_FINISH
  } state_t;

  typedef enum logic [1:0] {M_INSERT, M_QUERY, M_EVICT} mode_t;

  state_t             state_r, state_nxt;
  mode_t              mode_r, mode_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      stored_r, stored_nxt;
  logic [LEVEL_W-1:0] thr_r, thr_nxt;
  logic [63:0]        total_r, total_nxt;
  logic [HASH_W-1:0]  hash_r, hash_nxt;
  logic [QFREQ_W-1:0] q_r, q_nxt;
  logic               q_ok_r, q_ok_nxt;
  logic [LEVEL_W-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0]      issue_r, issue_nxt;
  logic               rvld_r, rvld_nxt;
  logic [AW-1:0]      raddr_r, raddr_nxt;
  logic [AW-1:0]      free_r, free_nxt;
  logic               free_ok_r, free_ok_nxt;
  logic [CW-1:0]      match_r, match_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t        ram_wdata, ram_rdata;

  logic [31:0] eff_limit;
  logic        evict_due;
  logic        rd_last;
  logic        q_in_range;
  logic        in_acc;

  askc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_CAPACITY)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_SAMPLE_LIMIT) ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == REG_SAMPLE_LIMIT) begin
      limit_r <= cfg_pwdata[LIMIT_W-1:0];
    end
  end

  // Clamp the limit to one .. capacity
  always_comb begin
    eff_limit = 32'(limit_r);
    if (eff_limit == 32'd0) eff_limit = 32'd1;
    if (eff_limit > 32'(TABLE_CAPACITY)) eff_limit = 32'(TABLE_CAPACITY);
  end

  assign evict_due  = (32'(stored_r) >= eff_limit) && (thr_r <= LEVEL_W'(TOP_LEVEL));
  assign rd_last    = (raddr_r == LAST_ADDR);
  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign q_in_range = (in_tdata[70:64] != '0) &&
                      (32'(in_tdata[70:64]) <= 32'(MAX_FREQUENCY));
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sequencer: read, modify and write back the table
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    stored_nxt    = stored_r;
    thr_nxt       = thr_r;
    total_nxt     = total_r;
    hash_nxt      = hash_r;
    q_nxt         = q_r;
    q_ok_nxt      = q_ok_r;
    lvl_nxt       = lvl_r;
    issue_nxt     = issue_r;
    rvld_nxt      = 1'b0;
    raddr_nxt     = raddr_r;
    free_nxt      = free_r;
    free_ok_nxt   = free_ok_r;
    match_nxt     = match_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = raddr_r;
    ram_wdata     = ram_rdata;
    ram_re        = 1'b0;
    ram_raddr     = issue_r[AW-1:0];

    // Drop the result once taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = issue_r[AW-1:0];
        ram_wdata = '0;
        issue_nxt = issue_r + 1'b1;
        if (issue_r == CW'(TABLE_CAPACITY - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_acc) begin
          hash_nxt  = in_tdata[63:0];
          q_nxt     = in_tdata[70:64];
          issue_nxt = '0;
          match_nxt = '0;
          free_ok_nxt = 1'b0;
          if (in_tuser == OP_QUERY) begin
            q_ok_nxt = q_in_range;
            mode_nxt = M_QUERY;
            state_nxt = q_in_range ? S_SCAN : S_FINISH;
          end else begin
            q_ok_nxt  = 1'b0;
            mode_nxt  = M_INSERT;
            total_nxt = total_r + 64'd1;
            state_nxt = S_LEVEL;
          end
        end
      end
      S_LEVEL: begin
        lvl_nxt   = trailing_level(hash_r);
        state_nxt = S_LVCHK;
      end
      S_LVCHK: begin
        state_nxt = (lvl_r < thr_r) ? S_FINISH : S_SCAN;
      end
      S_SCAN, S_EVICT: begin
        // Issue the next read
        if (issue_r < CAP) begin
          ram_re    = 1'b1;
          issue_nxt = issue_r + 1'b1;
          rvld_nxt  = 1'b1;
          raddr_nxt = issue_r[AW-1:0];
        end
        // Handle the returned entry
        if (rvld_r) begin
          case (mode_r)
            M_INSERT: begin
              if (ram_rdata.valid && ram_rdata.hash == hash_r) begin
                ram_we = 1'b1;
                if (ram_rdata.count != '1) ram_wdata.count = ram_rdata.count + 1'b1;
                rvld_nxt  = 1'b0;
                state_nxt = S_FINISH;
              end else begin
                if (!ram_rdata.valid && !free_ok_r) begin
                  free_nxt    = raddr_r;
                  free_ok_nxt = 1'b1;
                end
                if (rd_last) state_nxt = S_INSERT;
              end
            end
            M_QUERY: begin
              if (ram_rdata.valid && ram_rdata.count == COUNT_W'(q_r))
                match_nxt = match_r + 1'b1;
              if (rd_last) state_nxt = S_FINISH;
            end
            default: begin
              if (ram_rdata.valid && ram_rdata.level == thr_r) begin
                ram_we          = 1'b1;
                ram_wdata.valid = 1'b0;
                stored_nxt      = stored_r - 1'b1;
              end
              if (rd_last) begin
                thr_nxt   = thr_r + 1'b1;
                state_nxt = S_EVCHK;
              end
            end
          endcase
        end
      end
      S_INSERT: begin
        ram_we          = 1'b1;
        ram_waddr       = free_r;
        ram_wdata.valid = 1'b1;
        ram_wdata.level = lvl_r;
        ram_wdata.hash  = hash_r;
        ram_wdata.count = COUNT_W'(1);
        stored_nxt      = stored_r + 1'b1;
        state_nxt       = S_EVCHK;
      end
      S_EVCHK: begin
        issue_nxt = '0;
        if (evict_due) begin
          mode_nxt  = M_EVICT;
          state_nxt = S_EVICT;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {1'b0,
                           q_ok_r ? scale_sat(EST_W'(match_r), thr_r) : {EST_W{1'b0}},
                           total_r,
                           scale_sat(EST_W'(stored_r), thr_r),
                           thr_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      mode_r      <= M_INSERT;
      stored_r    <= '0;
      thr_r       <= '0;
      total_r     <= '0;
      issue_r     <= '0;
      rvld_r      <= 1'b0;
      free_ok_r   <= 1'b0;
      q_ok_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      stored_r    <= stored_nxt;
      thr_r       <= thr_nxt;
      total_r     <= total_nxt;
      issue_r     <= issue_nxt;
      rvld_r      <= rvld_nxt;
      free_ok_r   <= free_ok_nxt;
      q_ok_r      <= q_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hash_r     <= hash_nxt;
    q_r        <= q_nxt;
    lvl_r      <= lvl_nxt;
    raddr_r    <= raddr_nxt;
    free_r     <= free_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  // Table never holds more entries than it has rows
  a_stored_cap: assert property (@(posedge clk) disable iff (!rst_n) stored_r <= CAP)
    else $error("stored count above capacity");

  // Threshold never passes one above the top level
  a_thr_max: assert property (@(posedge clk) disable iff (!rst_n)
    thr_r <= LEVEL_W'(TOP_LEVEL + 1))
    else $error("threshold out of range");

  // No read is in flight while idle
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rvld_r)
    else $error("read pending in idle");

  // A new entry is only written where a free row was found
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_INSERT |-> free_ok_r)
    else $error("insert without free row");

endmodule
`default_nettype wire

/* design/askc_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none
module askc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* tb/sv/tb_adaptive_sampling_kmer_counter_top.sv */
// Self-checking testbench for the adaptive sampling k-mer counter: stream requests, compare stats.
`timescale 1ns / 1ps
`default_nettype none
module tb_adaptive_sampling_kmer_counter_top;
  import askc_pkg::*;

  localparam int           CAPACITY   = 4096;
  localparam int           MAX_FREQ   = 64;
  localparam longint       CYCLE_CAP  = 64'd80_000_000;
  localparam logic [63:0]  ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int           MAX_REPORT = 10;

  // One statistics record as it leaves the block
  typedef struct packed {
    logic [LEVEL_W-1:0] threshold;
    logic [EST_W-1:0]   distinct;
    logic [63:0]        total;
    logic [EST_W-1:0]   freq;
  } stats_t;

  // One directed request, with typed-in stats where they are obvious
  typedef struct packed {
    logic               op;
    logic [HASH_W-1:0]  hash;
    logic [QFREQ_W-1:0] qfreq;
    logic               typed;
    stats_t             stats;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_tuser;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tvalid;
  logic in_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  adaptive_sampling_kmer_counter_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // Sample table mirror: hash -> occurrence count
  logic [COUNT_W-1:0] sample_counts [logic [HASH_W-1:0]];
  int unsigned        sample_stored;
  logic [LEVEL_W-1:0] sample_thr;
  logic [63:0]        sample_total;
  logic [LIMIT_W-1:0] sample_limit;

  stats_t      pending_stats[$];
  logic [63:0] hash_pool[$];
  int          mismatches;
  int          stats_seen;
  int          inserts_sent;
  int          queries_sent;
  int          max_thr_seen;
  longint      cycle_count;
  bit          burst_mode;

  dir_row_t dir_rows [16] = '{
    '{OP_QUERY,  64'h0, 7'd1,   1'b1, '{7'd0, 64'd0, 64'd0, 64'd0}},
    '{OP_INSERT, ALL_ONES, 7'd0, 1'b1, '{7'd0, 64'd1, 64'd1, 64'd0}},
    '{OP_INSERT, ALL_ONES, 7'd0, 1'b1, '{7'd0, 64'd1, 64'd2, 64'd0}},
    '{OP_INSERT, 64'h0, 7'd0,   1'b1, '{7'd0, 64'd2, 64'd3, 64'd0}},
    '{OP_INSERT, 64'h8000_0000_0000_0000, 7'd0, 1'b1, '{7'd0, 64'd3, 64'd4, 64'd0}},
    '{OP_QUERY,  64'h0, 7'd2,   1'b1, '{7'd0, 64'd3, 64'd4, 64'd1}},
    '{OP_QUERY,  64'h0, 7'd1,   1'b1, '{7'd0, 64'd3, 64'd4, 64'd2}},
    '{OP_QUERY,  64'h0, 7'd0,   1'b1, '{7'd0, 64'd3, 64'd4, 64'd0}},
    '{OP_QUERY,  64'h0, 7'd64,  1'b1, '{7'd0, 64'd3, 64'd4, 64'd0}},
    '{OP_QUERY,  64'h0, 7'd65,  1'b1, '{7'd0, 64'd3, 64'd4, 64'd0}},
    '{OP_QUERY,  ALL_ONES, 7'd127, 1'b1, '{7'd0, 64'd3, 64'd4, 64'd0}},
    '{OP_INSERT, 64'h1, 7'd0,   1'b0, '0},
    '{OP_INSERT, 64'h2, 7'd0,   1'b0, '0},
    '{OP_INSERT, 64'h5555_5555_5555_5550, 7'd0, 1'b0, '0},
    '{OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 7'd0, 1'b0, '0},
    '{OP_QUERY,  64'h0, 7'd1,   1'b0, '0}
  };

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [LEVEL_W-1:0] level_of_hash(input logic [HASH_W-1:0] h);
    int n;
    if (h == '0) return LEVEL_W'(TOP_LEVEL);
    n = 0;
    while (!h[n]) n++;
    return LEVEL_W'(n);
  endfunction

  function automatic logic [63:0] shift_sat(input logic [63:0] v, input logic [LEVEL_W-1:0] sh);
    if (v == '0) return '0;
    if (sh >= 7'd64) return ALL_ONES;
    if (v > (ALL_ONES >> sh)) return ALL_ONES;
    return v << sh;
  endfunction

  // Advance the sample mirror by one request and return the stats it reports
  function automatic stats_t predict_stats(input logic op, input logic [HASH_W-1:0] h,
                                           input logic [QFREQ_W-1:0] qf);
    stats_t             s;
    logic [HASH_W-1:0]  doomed[$];
    int unsigned        eff_limit;
    longint unsigned    hits;
    eff_limit = (sample_limit == 0) ? 1 : ((sample_limit > CAPACITY) ? CAPACITY : sample_limit);
    hits = 0;
    if (op == OP_INSERT) begin
      sample_total++;
      if (level_of_hash(h) >= sample_thr) begin
        if (sample_counts.exists(h)) begin
          if (sample_counts[h] != '1) sample_counts[h]++;
        end else begin
          sample_counts[h] = 1;
          sample_stored++;
          // drop the lowest kept level while the limit is still reached
          while (sample_stored >= eff_limit && sample_thr <= 7'(TOP_LEVEL)) begin
            doomed.delete();
            foreach (sample_counts[k]) if (level_of_hash(k) == sample_thr) doomed.push_back(k);
            foreach (doomed[j]) sample_counts.delete(doomed[j]);
            sample_stored -= doomed.size();
            sample_thr++;
          end
        end
      end
    end else if (qf >= 1 && qf <= MAX_FREQ) begin
      foreach (sample_counts[k]) if (sample_counts[k] == qf) hits++;
    end
    s.threshold = sample_thr;
    s.distinct  = shift_sat(64'(sample_stored), sample_thr);
    s.total     = sample_total;
    s.freq      = (op == OP_INSERT) ? '0 : shift_sat(hits, sample_thr);
    return s;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Issue one request and log its predicted stats once accepted
  task automatic send_request(input logic op, input logic [HASH_W-1:0] h,
                              input logic [QFREQ_W-1:0] qf, input logic typed,
                              input stats_t typed_stats);
    stats_t s;
    int     gap;
    gap = pick_gap();
    // Drop the request during a gap; back to back requests keep it high
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, qf, h};
    do @(posedge clk); while (!in_tready);
    s = predict_stats(op, h, qf);
    pending_stats.push_back(typed ? typed_stats : s);
    if (op == OP_INSERT) inserts_sent++;
    else queries_sent++;
    if (s.threshold > max_thr_seen) max_thr_seen = s.threshold;
  endtask

  // Hash with a chosen trailing-zero level, often a repeat of an earlier one
  function automatic logic [HASH_W-1:0] pick_hash();
    logic [HASH_W-1:0] h;
    int                lvl;
    if (hash_pool.size() > 0 && $urandom_range(0, 99) < 35)
      return hash_pool[$urandom_range(0, hash_pool.size() - 1)];
    lvl = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 6) : $urandom_range(0, 64);
    h = {$urandom, $urandom} | 64'h1;
    h = (lvl == 64) ? '0 : (h << lvl);
    hash_pool.push_back(h);
    if (hash_pool.size() > 24) void'(hash_pool.pop_front());
    return h;
  endfunction

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) begin
      if (i % 48 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < 22)
        send_request(OP_QUERY, {$urandom, $urandom}, QFREQ_W'($urandom_range(0, 127)), 1'b0, '0);
      else
        send_request(OP_INSERT, pick_hash(), QFREQ_W'($urandom), 1'b0, '0);
    end
  endtask

  // Write sample_limit once the block has drained
  task automatic write_limit(input logic [LIMIT_W-1:0] value);
    in_tvalid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (8) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_SAMPLE_LIMIT;
    cfg_pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sample_limit = value;
  endtask

  // Stall the result side and check each accepted result
  always @(posedge clk) begin
    stats_t got;
    stats_t want;
    int     r;
    r = $urandom_range(0, 99);
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= burst_mode || (r < 70) || (r >= 97);
    if (rst_n && out_tvalid && out_tready) begin
      got.threshold = out_tdata[6:0];
      got.distinct  = out_tdata[70:7];
      got.total     = out_tdata[134:71];
      got.freq      = out_tdata[198:135];
      stats_seen++;
      if (pending_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("unexpected result %p", got);
      end else begin
        want = pending_stats.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORT)
            $display({"mismatch at result %0d: expected thr=%0d dist=%h tot=%h freq=%h,",
                      " got thr=%0d dist=%h tot=%h freq=%h"},
                     stats_seen, want.threshold, want.distinct, want.total, want.freq,
                     got.threshold, got.distinct, got.total, got.freq);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("timeout with %0d results outstanding", pending_stats.size());
      $display("tb_adaptive_sampling_kmer_counter_top NOT OK");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    mismatches = 0;
    stats_seen = 0;
    inserts_sent = 0;
    queries_sent = 0;
    max_thr_seen = 0;
    cycle_count = 0;
    burst_mode = 1'b0;
    sample_stored = 0;
    sample_thr = '0;
    sample_total = '0;
    sample_limit = LIMIT_RESET;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset limit
    foreach (dir_rows[i])
      send_request(dir_rows[i].op, dir_rows[i].hash, dir_rows[i].qfreq,
                   dir_rows[i].typed, dir_rows[i].stats);
    send_random(230);

    // Small limit, then lower it below the stored count
    write_limit(13'd16);
    send_random(250);
    write_limit(13'd4);
    send_random(150);

    // Above capacity acts as capacity; zero acts as one
    write_limit(13'd8191);
    send_random(200);
    write_limit(13'd0);
    send_random(100);

    // Push the threshold high enough to saturate the estimate
    write_limit(13'd2);
    send_random(100);
    send_request(OP_INSERT, 64'h8000_0000_0000_0000, '0, 1'b0, '0);
    send_request(OP_INSERT, 64'h0, '0, 1'b0, '0);
    send_request(OP_QUERY, '0, 7'd1, 1'b0, '0);

    // Drop every level: threshold past the top
    write_limit(13'd1);
    send_request(OP_INSERT, 64'h0, '0, 1'b0, '0);
    send_random(80);

    in_tvalid <= 1'b0;
    wait (pending_stats.size() == 0);
    repeat (CAPACITY + 64) @(posedge clk);
    $display("covered %0d inserts and %0d queries, %0d results checked, top threshold %0d",
             inserts_sent, queries_sent, stats_seen, max_thr_seen);
    $display("limits 4096, 16, 4, 8191, 0, 2 and 1; %0d mismatches", mismatches);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("tb_adaptive_sampling_kmer_counter_top OK");
    end else begin
      $display("tb_adaptive_sampling_kmer_counter_top NOT OK");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
design/askc_pkg.sv
design/askc_ram.sv
design/adaptive_sampling_kmer_counter_top.sv
tb/sv/tb_adaptive_sampling_kmer_counter_top.sv
